### rtl/qmp_pkg.sv
// ----------------------------------------------------------------------------
// qmp_pkg
// Shared widths, constants and types of the marginal probability block.
// ----------------------------------------------------------------------------
package qmp_pkg;

  localparam int unsigned QMP_MAX_QUBITS = 10;

  localparam int unsigned AmpW   = 16;  // signed Q1.15 amplitude part
  localparam int unsigned CountW = 4;   // qubit count register
  localparam int unsigned QnumW  = 4;   // qubit number of a result
  localparam int unsigned ProbW  = 42;  // unsigned Q12.30 probability
  localparam int unsigned SqW    = 31;  // one squared part, at most 2^30
  localparam int unsigned MagW   = 32;  // re^2 + im^2
  localparam int unsigned NumW   = 5;   // active qubit count, up to MAX_QUBITS
  localparam int unsigned DiffW  = ProbW + 2;

  localparam logic signed [DiffW-1:0] OneQ30  = 44'sh000_4000_0000;
  localparam logic signed [DiffW-1:0] ZeroMin = 44'shE00_0000_0000;

  // handoff of a finished run from the accumulator side to the result side
  typedef struct packed {
    logic            load;
    logic [NumW-1:0] num;
  } qmp_snap_t;

endpackage

### rtl/qmp_front.sv
// ----------------------------------------------------------------------------
// qmp_front
// Amplitude intake: squares, run index tracking and per-qubit accumulation.
// ----------------------------------------------------------------------------
module qmp_front import qmp_pkg::*; #(
  parameter int unsigned MAX_QUBITS = QMP_MAX_QUBITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CountW-1:0]       cfg_wdata_i,
  input  logic                    push_i,
  input  logic signed [AmpW-1:0]  amp_real_i,
  input  logic signed [AmpW-1:0]  amp_imag_i,
  output logic                    full_o,
  input  logic                    bank_free_i,
  output qmp_snap_t               snap_o,
  output logic [ProbW-1:0]        acc_o [MAX_QUBITS]
);

  localparam int unsigned CW = $clog2(MAX_QUBITS + 1);
  localparam int unsigned IW = (MAX_QUBITS > 1) ? $clog2(MAX_QUBITS) : 1;

  logic [CW-1:0]         n_q, n_d;
  logic [MAX_QUBITS-1:0] idx_q, idx_d;
  logic [MAX_QUBITS-1:0] last_idx;
  logic [MAX_QUBITS-1:0] mask;
  logic                  is_last;
  logic                  accept;

  logic                  s1_valid_q, s1_valid_d;
  logic                  s1_last_q;
  logic [MAX_QUBITS-1:0] s1_mask_q;
  logic [SqW-1:0]        s1_sq_re_q, s1_sq_im_q;
  logic signed [2*AmpW-1:0] sq_re, sq_im;
  logic                  s1_fire;
  logic [MagW-1:0]       mag;

  logic [ProbW-1:0]      acc_q [MAX_QUBITS];
  logic [ProbW-1:0]      acc_next [MAX_QUBITS];
  logic [ProbW:0]        acc_sum [MAX_QUBITS];

  // clamp the written count into 1..MAX_QUBITS
  always_comb begin
    logic [NumW-1:0] wr_ext;
    wr_ext = NumW'(cfg_wdata_i);
    if (wr_ext == '0) begin
      n_d = CW'(1);
    end else if (wr_ext > NumW'(MAX_QUBITS)) begin
      n_d = CW'(MAX_QUBITS);
    end else begin
      n_d = CW'(wr_ext);
    end
  end

  // last index of a run is n ones; qubit q looks at index bit n-1-q
  always_comb begin
    int pos;
    pos = 0;
    for (int b = 0; b < MAX_QUBITS; b++) begin
      last_idx[b] = (b < int'(n_q));
    end
    for (int q = 0; q < MAX_QUBITS; q++) begin
      pos = int'(n_q) - 1 - q;
      mask[q] = 1'b0;
      if (pos >= 0) begin
        mask[q] = idx_q[pos[IW-1:0]];
      end
    end
  end

  assign is_last = (idx_q == last_idx);

  // a final amplitude waits in stage one until the result bank is free
  assign s1_fire = s1_valid_q && (!s1_last_q || bank_free_i);
  assign full_o  = s1_valid_q && s1_last_q && !bank_free_i;
  assign accept  = push_i && !full_o;

  assign sq_re = amp_real_i * amp_real_i;
  assign sq_im = amp_imag_i * amp_imag_i;

  always_comb begin
    idx_d = idx_q;
    if (cfg_we_i) begin
      idx_d = '0;
    end else if (accept) begin
      idx_d = is_last ? '0 : idx_q + MAX_QUBITS'(1);
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  assign mag = MagW'(s1_sq_re_q) + MagW'(s1_sq_im_q);

  // parallel saturating adds, one per qubit lane
  always_comb begin
    for (int q = 0; q < MAX_QUBITS; q++) begin
      acc_sum[q]  = {1'b0, acc_q[q]} + (ProbW + 1)'(mag);
      acc_next[q] = acc_q[q];
      if (s1_mask_q[q]) begin
        acc_next[q] = acc_sum[q][ProbW] ? '1 : acc_sum[q][ProbW-1:0];
      end
    end
  end

  assign acc_o       = acc_next;
  assign snap_o.load = s1_fire && s1_last_q;
  assign snap_o.num  = NumW'(n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q        <= CW'(1);
      idx_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        n_q <= n_d;
      end
      idx_q      <= idx_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_last_q  <= is_last;
      s1_mask_q  <= mask;
      s1_sq_re_q <= SqW'(sq_re);
      s1_sq_im_q <= SqW'(sq_im);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int q = 0; q < MAX_QUBITS; q++) begin
        acc_q[q] <= '0;
      end
    end else begin
      for (int q = 0; q < MAX_QUBITS; q++) begin
        if (cfg_we_i || snap_o.load) begin
          acc_q[q] <= '0;
        end else if (s1_fire) begin
          acc_q[q] <= acc_next[q];
        end
      end
    end
  end

endmodule

### rtl/qmp_back.sv
// ----------------------------------------------------------------------------
// qmp_back
// Result bank of a finished run and the output register that drains it.
// ----------------------------------------------------------------------------
module qmp_back import qmp_pkg::*; #(
  parameter int unsigned MAX_QUBITS = QMP_MAX_QUBITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  qmp_snap_t               snap_i,
  input  logic [ProbW-1:0]        acc_i [MAX_QUBITS],
  output logic                    bank_free_o,
  input  logic                    pop_i,
  output logic                    empty_o,
  output logic [QnumW-1:0]        qubit_number_o,
  output logic [ProbW-1:0]        prob_one_o,
  output logic signed [ProbW-1:0] prob_zero_o,
  output logic                    last_result_o
);

  localparam int unsigned IW = (MAX_QUBITS > 1) ? $clog2(MAX_QUBITS) : 1;

  logic [ProbW-1:0]  bank_q [MAX_QUBITS];
  logic [NumW-1:0]   num_q;
  logic              busy_q;
  logic [IW-1:0]     ptr_q;
  logic              ptr_last;
  logic              load;
  logic              out_valid_q;
  logic [ProbW-1:0]  p1;
  logic signed [DiffW-1:0] diff;
  logic signed [ProbW-1:0] p0;

  assign bank_free_o = !busy_q;
  assign ptr_last    = ((NumW'(ptr_q) + NumW'(1)) == num_q);
  assign load        = busy_q && (!out_valid_q || pop_i);

  assign p1   = bank_q[ptr_q];
  assign diff = OneQ30 - $signed({2'b00, p1});
  assign p0   = (diff < ZeroMin) ? ZeroMin[ProbW-1:0] : diff[ProbW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (snap_i.load) begin
        busy_q <= 1'b1;
        ptr_q  <= '0;
      end else if (load) begin
        ptr_q <= ptr_q + IW'(1);
        if (ptr_last) begin
          busy_q <= 1'b0;
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_i.load) begin
      bank_q <= acc_i;
      num_q  <= snap_i.num;
    end
    if (load) begin
      qubit_number_o <= QnumW'(ptr_q);
      prob_one_o     <= p1;
      prob_zero_o    <= p0;
      last_result_o  <= ptr_last;
    end
  end

  assign empty_o = !out_valid_q;

endmodule

### rtl/qubit_marginal_probability_top.sv
// ----------------------------------------------------------------------------
// qubit_marginal_probability_top
// Marginal one/zero probabilities of every qubit of a streamed state vector.
// ----------------------------------------------------------------------------
// Usage:
//   Push the 2^n amplitudes of a state vector in index order on push/full;
//   one transaction is taken per cycle while full is low. Each part is
//   signed Q1.15. n comes from the qubit count register (0 acts as 1,
//   above MAX_QUBITS acts as MAX_QUBITS); write it with cfg_we_i only while
//   the block is idle. A write also restarts the run.
//   After the final amplitude of a run the block offers n results on
//   empty/pop, qubit 0 (the most significant index bit) first, with
//   last_result_o set on the final one. prob_zero_o saturates at -2^41.
//   With the result bank free, the final amplitude passes the square
//   register, then the result bank, then the output register before the
//   first result shows; further results follow one per cycle while pop
//   stays high. Throughput: one amplitude per cycle while full is low,
//   set by the two squarers and the parallel per-qubit adders. The
//   result bank holds one finished run; a final amplitude that arrives
//   while the previous run still drains holds in the square stage and
//   raises full until the bank empties.
//   Reset clears the run index, accumulators and all valid flags, sets the
//   qubit count to 1 and leaves empty high.
// ----------------------------------------------------------------------------
module qubit_marginal_probability_top import qmp_pkg::*; #(
  parameter int unsigned MAX_QUBITS = QMP_MAX_QUBITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CountW-1:0]       cfg_wdata_i,
  input  logic                    push,
  output logic                    full,
  input  logic signed [AmpW-1:0]  amp_real_i,
  input  logic signed [AmpW-1:0]  amp_imag_i,
  output logic                    empty,
  input  logic                    pop,
  output logic [QnumW-1:0]        qubit_number_o,
  output logic [ProbW-1:0]        prob_one_o,
  output logic signed [ProbW-1:0] prob_zero_o,
  output logic                    last_result_o
);

  qmp_snap_t        snap;
  logic             bank_free;
  logic [ProbW-1:0] acc [MAX_QUBITS];

  // front: squares each amplitude and adds it into the lanes of its set bits
  qmp_front #(
    .MAX_QUBITS(MAX_QUBITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .amp_real_i  (amp_real_i),
    .amp_imag_i  (amp_imag_i),
    .full_o      (full),
    .bank_free_i (bank_free),
    .snap_o      (snap),
    .acc_o       (acc)
  );

  // back: hold a finished run and drain it one qubit per transaction
  qmp_back #(
    .MAX_QUBITS(MAX_QUBITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .snap_i         (snap),
    .acc_i          (acc),
    .bank_free_o    (bank_free),
    .pop_i          (pop),
    .empty_o        (empty),
    .qubit_number_o (qubit_number_o),
    .prob_one_o     (prob_one_o),
    .prob_zero_o    (prob_zero_o),
    .last_result_o  (last_result_o)
  );

endmodule

### sim/qubit_marginal_probability_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qubit_marginal_probability_top_tb
// Streams state vectors through the marginal probability block and checks
// every per-qubit result against a cycle-free model of the accumulation.
// A short table covers reset state, qubit count clamping, restarts and the
// largest sums; random runs of random size follow, with bursty input, an
// irregular receiver and one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module qubit_marginal_probability_top_tb;
  import qmp_pkg::*;

  localparam int RANDOM_ITEMS = 130;
  localparam int DRAIN_CYCLES = 8;    // settle margin past the three register stages
  localparam int HOLD_CYCLES  = 80;   // long receiver hold-off
  localparam longint ONE_Q30    = longint'(1) << 30;
  localparam longint ACC_SAT    = (longint'(1) << ProbW) - 1;
  localparam longint ZERO_FLOOR = -(longint'(1) << (ProbW - 1));

  typedef struct packed {
    logic [QnumW-1:0]        qubit;
    logic [ProbW-1:0]        p_one;
    logic signed [ProbW-1:0] p_zero;
    logic                    last;
  } marginal_t;

  typedef enum logic [1:0] {ROW_AMP, ROW_CFG, ROW_FILL} row_kind_e;

  // One table row: a register write, one amplitude, or the same amplitude
  // repeated. Where typed is set, every result of the run that ends on this
  // row carries the given probabilities.
  typedef struct {
    row_kind_e               kind;
    logic [CountW-1:0]       count;
    logic signed [AmpW-1:0]  re;
    logic signed [AmpW-1:0]  im;
    int                      reps;
    bit                      typed;
    longint                  p_one;
    longint                  p_zero;
  } stim_row_t;

  localparam int NUM_ROWS = 20;

  stim_row_t rows [NUM_ROWS] = '{
    // reset count of one: qubit 0 only sees index 1
    '{ROW_AMP,  4'd0,  16'sh0000, 16'sh0000, 1,    1'b0, 0, 0},
    '{ROW_AMP,  4'd0,  16'sh8000, 16'sh8000, 1,    1'b1, 64'sd2147483648, -1073741824},
    '{ROW_AMP,  4'd0,  16'sh7FFF, 16'sh0000, 1,    1'b0, 0, 0},
    '{ROW_AMP,  4'd0,  16'sh0000, 16'sh7FFF, 1,    1'b1, 1073676289, 65535},
    // count zero acts as one
    '{ROW_CFG,  4'd0,  16'sh0000, 16'sh0000, 0,    1'b0, 0, 0},
    '{ROW_AMP,  4'd0,  16'sh8000, 16'sh0000, 1,    1'b0, 0, 0},
    '{ROW_AMP,  4'd0,  16'sh0000, 16'sh0000, 1,    1'b1, 0, 1073741824},
    // two qubits, uniform half amplitude
    '{ROW_CFG,  4'd2,  16'sh0000, 16'sh0000, 0,    1'b0, 0, 0},
    '{ROW_FILL, 4'd0,  16'sh4000, 16'sh0000, 4,    1'b1, 536870912, 536870912},
    // a write in the middle of a run restarts it
    '{ROW_CFG,  4'd1,  16'sh0000, 16'sh0000, 0,    1'b0, 0, 0},
    '{ROW_AMP,  4'd0,  16'sh0001, 16'shFFFF, 1,    1'b0, 0, 0},
    '{ROW_CFG,  4'd1,  16'sh0000, 16'sh0000, 0,    1'b0, 0, 0},
    '{ROW_AMP,  4'd0,  16'shFFFF, 16'sh0001, 1,    1'b0, 0, 0},
    '{ROW_AMP,  4'd0,  16'sh7FFF, 16'sh7FFF, 1,    1'b0, 0, 0},
    // count above the maximum acts as ten qubits; the next write cuts it short
    '{ROW_CFG,  4'd15, 16'sh0000, 16'sh0000, 0,    1'b0, 0, 0},
    '{ROW_FILL, 4'd0,  16'sh8000, 16'sh8000, 8,    1'b0, 0, 0},
    // three qubits, largest parts on every amplitude
    '{ROW_CFG,  4'd3,  16'sh0000, 16'sh0000, 0,    1'b0, 0, 0},
    '{ROW_FILL, 4'd0,  16'sh8000, 16'sh7FFF, 8,    1'b1, 64'sd8589672452, -64'sd7515930628},
    // all-zero vector
    '{ROW_CFG,  4'd4,  16'sh0000, 16'sh0000, 0,    1'b0, 0, 0},
    '{ROW_FILL, 4'd0,  16'sh0000, 16'sh0000, 16,   1'b1, 0, 1073741824}
  };

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CountW-1:0]       cfg_wdata_i;
  logic                    push;
  logic                    full;
  logic signed [AmpW-1:0]  amp_real_i;
  logic signed [AmpW-1:0]  amp_imag_i;
  logic                    empty;
  logic                    pop;
  logic [QnumW-1:0]        qubit_number_o;
  logic [ProbW-1:0]        prob_one_o;
  logic signed [ProbW-1:0] prob_zero_o;
  logic                    last_result_o;

  // table row of the amplitude on the input, -1 for random traffic
  int drv_tag;

  qubit_marginal_probability_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .amp_real_i     (amp_real_i),
    .amp_imag_i     (amp_imag_i),
    .empty          (empty),
    .pop            (pop),
    .qubit_number_o (qubit_number_o),
    .prob_one_o     (prob_one_o),
    .prob_zero_o    (prob_zero_o),
    .last_result_o  (last_result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Model of the block: qubit count, run position and per-qubit sums
  // --------------------------------------------------------------------------
  logic [CountW-1:0] model_count;
  int                amp_pos;
  longint            qubit_sums [QMP_MAX_QUBITS];
  marginal_t         pending_marginals [$];

  int errors;
  int amps_taken;
  int results_seen;
  int runs_closed;
  int full_stalls;
  int holds_done;

  // Bound the run well past the slowest legal schedule.
  initial begin
    #2_000_000;
    $display("Timeout at %0t with %0d results outstanding", $time, pending_marginals.size());
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void restart_run();
    amp_pos = 0;
    foreach (qubit_sums[q]) qubit_sums[q] = 0;
  endfunction

  // Fold one amplitude into the sums; on the final index of the run queue
  // one marginal per qubit, qubit 0 first, and restart.
  function automatic void predict_amplitude(logic signed [AmpW-1:0] re,
                                            logic signed [AmpW-1:0] im, int tag);
    int        n;
    longint    mag;
    longint    sum;
    longint    zero;
    marginal_t m;
    n = (model_count == 0) ? 1 :
        (model_count > QMP_MAX_QUBITS) ? QMP_MAX_QUBITS : int'(model_count);
    mag = longint'(re) * longint'(re) + longint'(im) * longint'(im);
    for (int q = 0; q < n; q++) begin
      if ((amp_pos >> (n - 1 - q)) & 1) begin
        sum = qubit_sums[q] + mag;
        qubit_sums[q] = (sum > ACC_SAT) ? ACC_SAT : sum;
      end
    end
    if (amp_pos >= (1 << n) - 1) begin
      for (int q = 0; q < n; q++) begin
        zero = ONE_Q30 - qubit_sums[q];
        if (zero < ZERO_FLOOR) zero = ZERO_FLOOR;
        m.qubit  = QnumW'(q);
        m.p_one  = ProbW'(qubit_sums[q]);
        m.p_zero = ProbW'(zero);
        m.last   = (q == n - 1);
        // hand-computed rows override the model's sums
        if (tag >= 0 && rows[tag].typed) begin
          m.p_one  = ProbW'(rows[tag].p_one);
          m.p_zero = ProbW'(rows[tag].p_zero);
        end
        pending_marginals.insert(pending_marginals.size(), m);
      end
      runs_closed++;
      restart_run();
    end else begin
      amp_pos++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: all transactions are taken from values sampled at the edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    marginal_t got;
    marginal_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        model_count = cfg_wdata_i;
        restart_run();
      end
      if (push && full) full_stalls++;
      if (push && !full) begin
        amps_taken++;
        predict_amplitude(amp_real_i, amp_imag_i, drv_tag);
      end
      if (pop && !empty) begin
        got = '{qubit_number_o, prob_one_o, prob_zero_o, last_result_o};
        results_seen++;
        if (pending_marginals.size() == 0) begin
          errors++;
          $display("%0t: unexpected result q=%0d one=%0d zero=%0d last=%0b", $time,
                   got.qubit, got.p_one, $signed(got.p_zero), got.last);
        end else begin
          want = pending_marginals.pop_front();
          if (got.qubit !== want.qubit || got.p_one !== want.p_one ||
              got.p_zero !== want.p_zero || got.last !== want.last) begin
            errors++;
            $display("%0t: mismatch expected q=%0d one=%0d zero=%0d last=%0b", $time,
                     want.qubit, want.p_one, $signed(want.p_zero), want.last);
            $display("%0t:          actual   q=%0d one=%0d zero=%0d last=%0b", $time,
                     got.qubit, got.p_one, $signed(got.p_zero), got.last);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: cycle through pop patterns; honor a hold-off request by
  // keeping pop low for a counted stretch.
  // --------------------------------------------------------------------------
  bit hold_req;

  initial begin
    int rx_cyc;
    rx_cyc = 0;
    pop <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      rx_cyc++;
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        holds_done++;
      end else begin
        case ((rx_cyc / 50) % 4)
          0:       pop <= 1'b1;                         // drain at full rate
          1:       pop <= ($urandom_range(0, 1) == 0);
          2:       pop <= ($urandom_range(0, 3) == 0);  // slow consumer
          default: pop <= ((rx_cyc / 3) % 2 == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  int burst_left;
  bit eager;   // no gaps between transactions

  // Offer one amplitude, after a random gap at the start of each burst,
  // and hold it until the transaction completes.
  task automatic offer_amplitude(logic signed [AmpW-1:0] re, logic signed [AmpW-1:0] im,
                                 int tag);
    int gap;
    if (burst_left == 0) begin
      gap = eager ? 0 : $urandom_range(0, 5);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    push       <= 1'b1;
    amp_real_i <= re;
    amp_imag_i <= im;
    drv_tag    <= tag;
    do @(posedge clk_i); while (full);
  endtask

  // Stop sending, wait for every expected result, then let the pipeline
  // settle in case trailing amplitudes are still in flight.
  task automatic quiesce();
    push <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_marginals.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_count(logic [CountW-1:0] value);
    quiesce();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Favor the extremes of a Q1.15 part.
  function automatic logic signed [AmpW-1:0] rand_amp();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      default: return AmpW'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int random_items;
    int phase;
    int n;
    int runs;
    int len;
    logic [CountW-1:0] count;

    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    push        <= 1'b0;
    amp_real_i  <= '0;
    amp_imag_i  <= '0;
    drv_tag     <= -1;
    hold_req    = 1'b0;
    eager       = 1'b0;
    burst_left  = 0;
    errors      = 0;
    amps_taken  = 0;
    results_seen = 0;
    runs_closed = 0;
    full_stalls = 0;
    holds_done  = 0;
    model_count = CountW'(1);
    restart_run();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table.
    for (int r = 0; r < NUM_ROWS; r++) begin
      case (rows[r].kind)
        ROW_CFG:  write_count(rows[r].count);
        ROW_AMP:  offer_amplitude(rows[r].re, rows[r].im, r);
        default:  repeat (rows[r].reps) offer_amplitude(rows[r].re, rows[r].im, r);
      endcase
    end

    // Random runs: each phase sets a qubit count and streams whole vectors;
    // a phase may end with a vector cut short, which the next write restarts.
    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      phase++;
      eager = (phase % 3 == 0);
      if (phase == 2) begin
        // Hold the receiver off while back-to-back short runs pile up.
        write_count(CountW'(1));
        eager = 1'b1;
        hold_req = 1'b1;
        repeat (24) begin
          offer_amplitude(rand_amp(), rand_amp(), -1);
          random_items++;
        end
      end else begin
        count = ($urandom_range(0, 7) == 0) ? CountW'(0) : CountW'($urandom_range(1, 5));
        write_count(count);
        n = (count == 0) ? 1 : int'(count);
        runs = (phase == 3) ? 3 : $urandom_range(1, 3);
        for (int k = 0; k < runs; k++) begin
          len = 1 << n;
          if (k == runs - 1 && $urandom_range(0, 5) == 0) len = $urandom_range(1, len - 1);
          // pause until every result is out before some runs
          if (k > 0 && (phase == 3 || $urandom_range(0, 4) == 0)) quiesce();
          repeat (len) begin
            offer_amplitude(rand_amp(), rand_amp(), -1);
            random_items++;
          end
        end
      end
    end

    quiesce();
    $display("Covered %0d amplitudes in %0d completed vectors, %0d results checked,",
             amps_taken, runs_closed, results_seen);
    $display("%0d input stall cycles, %0d receiver hold-offs, qubit counts 0 to 5 and 15",
             full_stalls, holds_done);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d errors", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
